// ===== rtl/core/irai_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR range averager package
// Widths, breakpoint and reciprocal tables, status codes and queue status
// shared by the front, queue and back modules.
// ----------------------------------------------------------------------------
package irai_pkg;

    localparam int ADC_W             = 10;
    localparam int DIST_W            = 11;
    localparam int STAT_W            = 2;
    localparam int TABLE_LEN         = 8;
    localparam int SEG_CNT           = TABLE_LEN - 1;
    localparam int SEG_W             = $clog2(SEG_CNT);
    localparam int RECIP_W           = 21;
    localparam int DIFF_W            = 9;
    localparam int RECIP_FRAC        = 16;
    localparam int OFF_W             = 9;
    localparam int QUEUE_DEPTH       = 2;
    localparam int AVG_SAMPLES_DEF   = 8;
    localparam int TABLE_POINTS_DEF  = 8;

    localparam logic [DIST_W-1:0] NEAR_DIST = 11'd160;
    localparam logic [DIST_W-1:0] FAR_DIST  = 11'd0;

    localparam logic [ADC_W-1:0] BP_CODE [TABLE_LEN] = '{
        10'd614, 10'd327, 10'd225, 10'd164, 10'd133, 10'd113, 10'd92, 10'd82
    };

    // Q16 sixteenths per converter code, rounded half up
    localparam logic [RECIP_W-1:0] SEG_RECIP [SEG_CNT] = '{
        21'd36536, 21'd102802, 21'd171898, 21'd338250,
        21'd524288, 21'd499322, 21'd1048576
    };

    // distance at the far end of each segment
    localparam logic [DIST_W-1:0] SEG_END_DIST [SEG_CNT] = '{
        11'd320, 11'd480, 11'd640, 11'd800, 11'd960, 11'd1120, 11'd1280
    };

    typedef enum logic [STAT_W-1:0] {
        RS_INSIDE = 2'd0,
        RS_NEAR   = 2'd1,
        RS_FAR    = 2'd2
    } t_range_status;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

// ===== rtl/core/irai_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR range averager front end
// Accepts converter samples, sums each block and pushes the block sum.
// ----------------------------------------------------------------------------
module irai_front #(
    parameter int AVG_SAMPLES = irai_pkg::AVG_SAMPLES_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic [irai_pkg::ADC_W-1:0]             i_adc_sample,
    input  wire irai_pkg::t_q_stat                      i_q_stat,
    output logic                                        o_push,
    output logic [irai_pkg::ADC_W+$clog2(AVG_SAMPLES)-1:0] o_push_sum
);
    import irai_pkg::*;

    localparam int SUM_W = ADC_W + $clog2(AVG_SAMPLES);
    localparam int CNT_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVG_SAMPLES - 1);

    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_last;
    logic             w_accept;
    logic [SUM_W-1:0] w_sum_inc;

    assign w_last     = (r_cnt == CNT_LAST);
    assign o_stall    = w_last && i_q_stat.full;
    assign w_accept   = i_valid && !o_stall;
    assign w_sum_inc  = r_sum + SUM_W'(i_adc_sample);
    assign o_push     = w_accept && w_last;
    assign o_push_sum = w_sum_inc;

    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        if (w_accept) begin
            if (w_last) begin
                n_sum = '0;
                n_cnt = '0;
            end else begin
                n_sum = w_sum_inc;
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/irai_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR range averager block queue
// Two-entry queue of block sums between the front and back ends.
// ----------------------------------------------------------------------------
module irai_queue #(
    parameter int DATA_W = irai_pkg::ADC_W + $clog2(irai_pkg::AVG_SAMPLES_DEF)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_push_data,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_pop_data,
    output irai_pkg::t_q_stat      o_stat
);
    import irai_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  n_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [PTR_W-1:0]  n_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;

    assign o_stat.full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_pop_data   = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? r_wr + PTR_W'(1) : r_wr;
        n_rd  = i_pop  ? r_rd + PTR_W'(1) : r_rd;
        n_cnt = r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/irai_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR range averager back end
// Four-stage pipeline: average by reciprocal multiply, segment select,
// offset multiply, distance and output register.
// ----------------------------------------------------------------------------
module irai_back #(
    parameter int AVG_SAMPLES  = irai_pkg::AVG_SAMPLES_DEF,
    parameter int TABLE_POINTS = irai_pkg::TABLE_POINTS_DEF
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire irai_pkg::t_q_stat                          i_q_stat,
    input  wire logic [irai_pkg::ADC_W+$clog2(AVG_SAMPLES)-1:0] i_pop_data,
    output logic                                            o_pop,
    output logic                                            o_valid,
    input  wire logic                                       i_stall,
    output logic [irai_pkg::ADC_W-1:0]                      o_average_raw,
    output logic [irai_pkg::DIST_W-1:0]                     o_distance_sixteenths,
    output logic [irai_pkg::STAT_W-1:0]                     o_range_status
);
    import irai_pkg::*;

    localparam int AVG_LOG   = $clog2(AVG_SAMPLES);
    localparam int SUM_W     = ADC_W + AVG_LOG;
    localparam int MUL_W     = SUM_W + 1;
    localparam int PROD1_W   = SUM_W + MUL_W;
    localparam int AVG_SHIFT = SUM_W + AVG_LOG;
    localparam logic [63:0] AVG_MUL_FULL =
        ((64'd1 << AVG_SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / AVG_SAMPLES;
    localparam logic [MUL_W-1:0] AVG_MUL = AVG_MUL_FULL[MUL_W-1:0];
    localparam int PTS_USED = (TABLE_POINTS < 2) ? 2 :
                              ((TABLE_POINTS > TABLE_LEN) ? TABLE_LEN : TABLE_POINTS);
    localparam int PROD2_W  = DIFF_W + RECIP_W;
    localparam logic [PROD2_W:0] ROUND_HALF = (PROD2_W + 1)'(1) << (RECIP_FRAC - 1);

    logic                 en_s1;
    logic                 en_s2;
    logic                 en_s3;
    logic                 en_s4;

    logic                 r_s1_v;
    logic [PROD1_W-1:0]   r_s1_prod;

    logic                 r_s2_v;
    logic [ADC_W-1:0]     r_s2_avg;
    t_range_status        r_s2_stat;
    logic [SEG_W-1:0]     r_s2_seg;
    logic [DIFF_W-1:0]    r_s2_diff;
    logic [RECIP_W-1:0]   r_s2_recip;

    logic                 r_s3_v;
    logic [ADC_W-1:0]     r_s3_avg;
    t_range_status        r_s3_stat;
    logic [SEG_W-1:0]     r_s3_seg;
    logic [PROD2_W-1:0]   r_s3_prod;

    logic                 r_s4_v;
    logic [ADC_W-1:0]     r_s4_avg;
    logic [DIST_W-1:0]    r_s4_dist;
    t_range_status        r_s4_stat;

    logic [ADC_W-1:0]     w_avg;
    t_range_status        n_s2_stat;
    logic [SEG_W-1:0]     n_s2_seg;
    logic [DIFF_W-1:0]    n_s2_diff;
    logic [RECIP_W-1:0]   n_s2_recip;
    logic [PROD2_W:0]     w_rnd;
    logic [OFF_W-1:0]     w_off;
    logic [DIST_W-1:0]    n_s4_dist;

    assign en_s4 = !r_s4_v || !i_stall;
    assign en_s3 = !r_s3_v || en_s4;
    assign en_s2 = !r_s2_v || en_s3;
    assign en_s1 = !r_s1_v || en_s2;
    assign o_pop = en_s1 && !i_q_stat.empty;

    assign w_avg = r_s1_prod[AVG_SHIFT +: ADC_W];

    always_comb begin
        n_s2_seg   = '0;
        n_s2_diff  = '0;
        n_s2_recip = '0;
        for (int i = SEG_CNT - 1; i >= 0; i--) begin
            if (i < PTS_USED - 1 && w_avg <= BP_CODE[i] && w_avg >= BP_CODE[i+1]) begin
                n_s2_seg   = SEG_W'(i);
                n_s2_diff  = DIFF_W'(w_avg - BP_CODE[i+1]);
                n_s2_recip = SEG_RECIP[i];
            end
        end
        if (w_avg > BP_CODE[0]) begin
            n_s2_stat = RS_NEAR;
        end else if (w_avg < BP_CODE[PTS_USED-1]) begin
            n_s2_stat = RS_FAR;
        end else begin
            n_s2_stat = RS_INSIDE;
        end
    end

    assign w_rnd = {1'b0, r_s3_prod} + ROUND_HALF;
    assign w_off = w_rnd[RECIP_FRAC +: OFF_W];

    always_comb begin
        case (r_s3_stat)
            RS_NEAR:   n_s4_dist = NEAR_DIST;
            RS_FAR:    n_s4_dist = FAR_DIST;
            RS_INSIDE: n_s4_dist = SEG_END_DIST[r_s3_seg] - DIST_W'(w_off);
            default:   n_s4_dist = FAR_DIST;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            if (en_s1) r_s1_v <= !i_q_stat.empty;
            if (en_s2) r_s2_v <= r_s1_v;
            if (en_s3) r_s3_v <= r_s2_v;
            if (en_s4) r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_prod <= PROD1_W'(i_pop_data) * PROD1_W'(AVG_MUL);
        end
        if (en_s2 && r_s1_v) begin
            r_s2_avg   <= w_avg;
            r_s2_stat  <= n_s2_stat;
            r_s2_seg   <= n_s2_seg;
            r_s2_diff  <= n_s2_diff;
            r_s2_recip <= n_s2_recip;
        end
        if (en_s3 && r_s2_v) begin
            r_s3_avg  <= r_s2_avg;
            r_s3_stat <= r_s2_stat;
            r_s3_seg  <= r_s2_seg;
            r_s3_prod <= PROD2_W'(r_s2_diff) * PROD2_W'(r_s2_recip);
        end
        if (en_s4 && r_s3_v) begin
            r_s4_avg  <= r_s3_avg;
            r_s4_dist <= n_s4_dist;
            r_s4_stat <= r_s3_stat;
        end
    end

    assign o_valid               = r_s4_v;
    assign o_average_raw         = r_s4_avg;
    assign o_distance_sixteenths = r_s4_dist;
    assign o_range_status        = r_s4_stat;

endmodule
`default_nettype wire

// ===== rtl/core/ir_range_average_interpolate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR range averager and distance interpolator
// Input channel: one 10-bit converter sample per word (i_valid / o_stall).
// Every AVG_SAMPLES samples form a block; the block gives one output word
// (o_valid / i_stall) with the truncated mean, the distance in 1/16 cm by
// piecewise-linear interpolation over the breakpoint table, and a status:
// inside, near (clamped to 10 cm) or far (distance 0).
// Throughput: one sample per cycle while o_stall is low, set by the
// accumulator in the front end and the fully pipelined back end.
// Result path: the block sum enters the queue at the edge that takes the
// last sample of a block; from there the average multiply, the segment
// select, the offset multiply and the distance register are loaded in
// turn before its result word is shown.
// Reset clears the running sum, the sample count, the queue and all stage
// valids; no result is pending after reset.
// When the receiver stalls, the result holds and the pipeline fills; the
// two-entry queue then fills, and o_stall rises only for a sample that
// would complete a block while the queue is full.
// ----------------------------------------------------------------------------
module ir_range_average_interpolate #(
    parameter int AVG_SAMPLES  = irai_pkg::AVG_SAMPLES_DEF,
    parameter int TABLE_POINTS = irai_pkg::TABLE_POINTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [irai_pkg::ADC_W-1:0]   i_adc_sample,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [irai_pkg::ADC_W-1:0]        o_average_raw,
    output logic [irai_pkg::DIST_W-1:0]       o_distance_sixteenths,
    output logic [irai_pkg::STAT_W-1:0]       o_range_status
);
    import irai_pkg::*;

    localparam int SUM_W = ADC_W + $clog2(AVG_SAMPLES);

    t_q_stat          w_q_stat;
    logic             w_push;
    logic [SUM_W-1:0] w_push_sum;
    logic             w_pop;
    logic [SUM_W-1:0] w_pop_sum;

    irai_front #(
        .AVG_SAMPLES (AVG_SAMPLES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_adc_sample (i_adc_sample),
        .i_q_stat     (w_q_stat),
        .o_push       (w_push),
        .o_push_sum   (w_push_sum)
    );

    irai_queue #(
        .DATA_W (SUM_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_sum),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_sum),
        .o_stat      (w_q_stat)
    );

    irai_back #(
        .AVG_SAMPLES  (AVG_SAMPLES),
        .TABLE_POINTS (TABLE_POINTS)
    ) u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_q_stat              (w_q_stat),
        .i_pop_data            (w_pop_sum),
        .o_pop                 (w_pop),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_average_raw         (o_average_raw),
        .o_distance_sixteenths (o_distance_sixteenths),
        .o_range_status        (o_range_status)
    );

endmodule
`default_nettype wire
